@@ design/gmd_pkg.sv @@
// Package for the grid maze depth-first search unit.
// Holds the item types, grid cell codes and sequencer state; no dependencies.
package gmd_pkg;

  // One input item: load a cell or start a search.
  typedef struct packed {
    logic       action;
    logic [3:0] row;
    logic [3:0] col;
    logic       cell_open;
  } gmd_in_t;

  // One result item, produced by a search.
  typedef struct packed {
    logic        reached;
    logic        overflow;
    logic [11:0] cells_expanded;
  } gmd_out_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SOLVE = 1'b1;

  // Grid cell codes. A visited cell is written back as a wall.
  localparam logic [1:0] CELL_WALL  = 2'd0;
  localparam logic [1:0] CELL_OPEN  = 2'd1;
  localparam logic [1:0] CELL_GOAL  = 2'd2;
  localparam logic [1:0] CELL_START = 2'd3;

  localparam logic [11:0] COUNT_MAX = 12'd4095;

  localparam logic [4:0] SIDE_RESET = 5'd16;

  // Neighbor scan order.
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } gmd_dir_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_INIT = 3'd1,
    S_POP  = 3'd2,
    S_TOP  = 3'd3,
    S_NRD  = 3'd4,
    S_NCHK = 3'd5
  } gmd_state_t;

endpackage

@@ design/gmd_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Used for the grid cells and the coordinate stack; no package dependencies.
module gmd_ram #(
  parameter int AW = 8,
  parameter int DW = 2
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/grid_maze_dfs_search_unit.sv @@
// Grid maze depth-first search unit (top level); uses gmd_pkg and gmd_ram.
// Load item: busy stays low, no result; loads may arrive every cycle.
// Solve item: a setup state, then per popped cell a pop and a top state, plus a read
//   state per neighbor and a check state per neighbor on the grid, and one more pop when
//   the stack runs empty. The result strobe comes in the cycle after the search ends;
//   busy is low again in that cycle.
// Reset (rst_n, synchronous): sequencer idle, stack empty, grid_side 16. Grid and
//   stack RAMs are not cleared. The receiver cannot stall results.
module grid_maze_dfs_search_unit #(
  parameter int MAX_SIDE    = 16,
  parameter int STACK_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  // command channel
  input  logic            start,
  output logic            busy,
  input  gmd_pkg::gmd_in_t  in_item,
  // result channel
  output logic            out_valid,
  output gmd_pkg::gmd_out_t out_result,
  // configuration channel
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [4:0]      cfg_grid_side
);

  import gmd_pkg::*;

  // Coordinate widths. Grid entries are addressed as {row, col}.
  localparam int RW  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int GAW = 2 * RW;
  localparam int IW  = (RW > 4) ? RW : 4;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int FW  = $clog2(STACK_DEPTH + 1);
  localparam logic [7:0] SIDE_MAX8 = 8'(MAX_SIDE);
  localparam logic [FW-1:0] FILL_FULL = FW'(STACK_DEPTH);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  gmd_state_t     state_r, state_nxt;
  gmd_dir_t       dir_r, dir_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [11:0]    cnt_r, cnt_nxt;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [RW-1:0]  cur_col_r, cur_col_nxt;
  logic [4:0]     side_r;
  logic           out_valid_r, out_valid_nxt;
  gmd_out_t       out_result_r, out_result_nxt;

  // ---------------------------------------------------------------------------
  // Memory ports
  // ---------------------------------------------------------------------------
  logic           grid_we;
  logic [GAW-1:0] grid_waddr;
  logic [1:0]     grid_wdata;
  logic [GAW-1:0] grid_raddr;
  logic [1:0]     grid_rdata;

  logic           stk_we;
  logic [SAW-1:0] stk_waddr;
  logic [GAW-1:0] stk_wdata;
  logic [SAW-1:0] stk_raddr;
  logic [GAW-1:0] stk_rdata;

  // ---------------------------------------------------------------------------
  // Handshakes and configuration
  // ---------------------------------------------------------------------------
  logic in_acc;

  assign busy      = (state_r != S_IDLE);
  assign in_acc    = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      side_r <= cfg_grid_side;
    end
  end

  // Clamp the side into 2..MAX_SIDE and keep side-1, the last active row/col.
  logic [7:0]    side_ext;
  logic [7:0]    side_lim;
  logic [RW-1:0] last_rc;

  assign side_ext = 8'(side_r);
  always_comb begin
    if (side_ext < 8'd2) begin
      side_lim = 8'd2;
    end else if (side_ext > SIDE_MAX8) begin
      side_lim = SIDE_MAX8;
    end else begin
      side_lim = side_ext;
    end
  end
  assign last_rc = RW'(side_lim - 8'd1);

  // Load address; loads outside the store are dropped.
  logic [IW-1:0] ld_row_ext;
  logic [IW-1:0] ld_col_ext;
  logic          ld_in_range;

  assign ld_row_ext  = IW'(in_item.row);
  assign ld_col_ext  = IW'(in_item.col);
  assign ld_in_range = (32'(in_item.row) < 32'(MAX_SIDE)) &&
                       (32'(in_item.col) < 32'(MAX_SIDE));

  // ---------------------------------------------------------------------------
  // Neighbor of the current cell in the scan direction
  // ---------------------------------------------------------------------------
  logic          nbr_ok;
  logic [RW-1:0] nbr_row;
  logic [RW-1:0] nbr_col;

  always_comb begin
    nbr_row = cur_row_r;
    nbr_col = cur_col_r;
    nbr_ok  = 1'b0;
    case (dir_r)
      DIR_UP: begin
        nbr_ok  = (cur_row_r != '0);
        nbr_row = cur_row_r - RW'(1);
      end
      DIR_DOWN: begin
        nbr_ok  = (cur_row_r < last_rc);
        nbr_row = cur_row_r + RW'(1);
      end
      DIR_RIGHT: begin
        nbr_ok  = (cur_col_r < last_rc);
        nbr_col = cur_col_r + RW'(1);
      end
      DIR_LEFT: begin
        nbr_ok  = (cur_col_r != '0);
        nbr_col = cur_col_r - RW'(1);
      end
      default: begin
        nbr_ok = 1'b0;
      end
    endcase
  end

  logic fill_empty;
  logic fill_full;
  logic last_dir;

  assign fill_empty = (fill_r == '0);
  assign fill_full  = (fill_r == FILL_FULL);
  assign last_dir   = (dir_r == DIR_LEFT);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_item.action == ACT_SOLVE) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        state_nxt = fill_empty ? S_IDLE : S_TOP;
      end
      S_TOP: begin
        state_nxt = S_NRD;
      end
      S_NRD: begin
        if (nbr_ok) begin
          state_nxt = S_NCHK;
        end else if (last_dir) begin
          state_nxt = S_POP;
        end
      end
      S_NCHK: begin
        if (grid_rdata == CELL_GOAL) begin
          state_nxt = S_IDLE;
        end else if (grid_rdata == CELL_OPEN && fill_full) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = last_dir ? S_POP : S_NRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control
  // The grid is only written on a load, the goal setup, or the pop of a cell,
  // and only read one neighbor at a time afterwards; the sequencing keeps every
  // read in a later cycle than any write to the same entry, so no
  // forwarding is needed. The same holds for stack push and pop.
  // ---------------------------------------------------------------------------
  always_comb begin
    dir_nxt        = dir_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;

    grid_we    = 1'b0;
    grid_waddr = {nbr_row, nbr_col};
    grid_wdata = CELL_WALL;
    grid_raddr = {nbr_row, nbr_col};

    stk_we    = 1'b0;
    stk_waddr = fill_r[SAW-1:0];
    stk_wdata = {nbr_row, nbr_col};
    stk_raddr = fill_r[SAW-1:0];

    case (state_r)
      S_IDLE: begin
        // Write a loaded cell straight into the grid.
        if (in_acc && in_item.action == ACT_LOAD && ld_in_range) begin
          grid_we    = 1'b1;
          grid_waddr = {ld_row_ext[RW-1:0], ld_col_ext[RW-1:0]};
          grid_wdata = in_item.cell_open ? CELL_OPEN : CELL_WALL;
        end
      end
      S_INIT: begin
        // Mark the goal and push the start cell on a fresh stack. The start
        // cell's own mark is never read: it is popped first and walled then.
        grid_we    = 1'b1;
        grid_waddr = {last_rc, last_rc};
        grid_wdata = CELL_GOAL;
        stk_we     = 1'b1;
        stk_waddr  = '0;
        stk_wdata  = '0;
        fill_nxt   = FW'(1);
        cnt_nxt    = '0;
      end
      S_POP: begin
        if (fill_empty) begin
          out_valid_nxt                 = 1'b1;
          out_result_nxt.reached        = 1'b0;
          out_result_nxt.overflow       = 1'b0;
          out_result_nxt.cells_expanded = cnt_r;
        end else begin
          stk_raddr = SAW'(fill_r - FW'(1));
          fill_nxt  = fill_r - FW'(1);
          if (cnt_r != COUNT_MAX) begin
            cnt_nxt = cnt_r + 12'd1;
          end
        end
      end
      S_TOP: begin
        // Latch the popped cell and wall it off.
        cur_row_nxt = stk_rdata[GAW-1:RW];
        cur_col_nxt = stk_rdata[RW-1:0];
        grid_we     = 1'b1;
        grid_waddr  = stk_rdata;
        grid_wdata  = CELL_WALL;
        dir_nxt     = DIR_UP;
      end
      S_NRD: begin
        // Issue the neighbor read, or skip a neighbor off the grid.
        if (!nbr_ok && !last_dir) begin
          dir_nxt = gmd_dir_t'(dir_r + 2'd1);
        end
      end
      S_NCHK: begin
        if (grid_rdata == CELL_GOAL) begin
          out_valid_nxt                 = 1'b1;
          out_result_nxt.reached        = 1'b1;
          out_result_nxt.overflow       = 1'b0;
          out_result_nxt.cells_expanded = cnt_r;
        end else if (grid_rdata == CELL_OPEN && fill_full) begin
          out_valid_nxt                 = 1'b1;
          out_result_nxt.reached        = 1'b0;
          out_result_nxt.overflow       = 1'b1;
          out_result_nxt.cells_expanded = cnt_r;
        end else begin
          if (grid_rdata == CELL_OPEN) begin
            stk_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end
          if (!last_dir) begin
            dir_nxt = gmd_dir_t'(dir_r + 2'd1);
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r        <= dir_nxt;
    cnt_r        <= cnt_nxt;
    cur_row_r    <= cur_row_nxt;
    cur_col_r    <= cur_col_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // ---------------------------------------------------------------------------
  // Storage
  // ---------------------------------------------------------------------------
  gmd_ram #(
    .AW (GAW),
    .DW (2)
  ) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  gmd_ram #(
    .AW (SAW),
    .DW (GAW)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("stack fill beyond depth");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while search still running");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_result.reached && out_result.overflow))
    else $error("reached and overflow both set");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP && fill_empty) |=> (out_valid && !out_result.reached))
    else $error("empty stack did not end the search");

endmodule

@@ tb/sv/grid_maze_dfs_search_unit_test.sv @@
// Self-checking testbench for grid_maze_dfs_search_unit: cell loads, searches and side writes.
// Depends on gmd_pkg and the unit under test. A scoreboard class predicts each search
// result from its own copy of the grid and the side register.
`timescale 1ns / 1ps

module grid_maze_dfs_search_unit_test;
  import gmd_pkg::*;

  localparam int GRID_DIM      = 16;      // store side, matches the MAX_SIDE parameter
  localparam int STACK_LIMIT   = 1024;    // coordinate stack depth of the unit
  localparam int MIN_SIDE      = 2;
  localparam int ITEM_TARGET   = 2000;    // stop starting new phases past this many items
  localparam int SETTLE_CYCLES = 8;       // quiet cycles after the last result of a phase
  localparam int STALL_LIMIT   = 200000;  // watchdog: edges with no progress before giving up

  // Scoreboard: mirrors the grid and side register, predicts one result per search
  // and compares results against the oldest prediction.
  class maze_scoreboard;
    typedef enum {PROBE_GO_ON, PROBE_GOAL, PROBE_FULL} probe_t;

    logic [1:0]  cells [GRID_DIM*GRID_DIM];
    logic [7:0]  trail [$];
    logic [4:0]  side_reg;
    gmd_out_t    expected_q [$];
    int unsigned errors;

    function new();
      side_reg = SIDE_RESET;
      errors   = 0;
    endfunction

    static function int unsigned clamp_side(logic [4:0] v);
      if (v < MIN_SIDE) return MIN_SIDE;
      if (v > GRID_DIM) return GRID_DIM;
      return v;
    endfunction

    function void set_side(logic [4:0] v);
      side_reg = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Look at one neighbor: push it when open, flag the goal, flag a full stack.
    function probe_t probe(int unsigned r, int unsigned c);
      logic [1:0] v;
      v = cells[r*GRID_DIM + c];
      if (v == CELL_OPEN) begin
        if (trail.size() >= STACK_LIMIT) return PROBE_FULL;
        trail.push_back(8'(r*GRID_DIM + c));
      end
      if (v == CELL_GOAL) return PROBE_GOAL;
      return PROBE_GO_ON;
    endfunction

    function gmd_out_t search_maze();
      int unsigned side, r, c, count;
      logic [7:0]  at;
      probe_t      hit;
      gmd_out_t    res;
      side = clamp_side(side_reg);
      cells[0] = CELL_START;
      cells[(side-1)*GRID_DIM + side - 1] = CELL_GOAL;
      trail.delete();
      trail.push_back(8'd0);
      count = 0;
      res = '0;
      while (trail.size() != 0) begin
        at = trail.pop_back();
        r = at / GRID_DIM;
        c = at % GRID_DIM;
        if (count < COUNT_MAX) count++;
        cells[at] = CELL_WALL;
        // neighbor order: up, down, right, left; stop on the first goal or full stack
        hit = PROBE_GO_ON;
        if (r >= 1) hit = probe(r - 1, c);
        if (hit == PROBE_GO_ON && r + 1 < side) hit = probe(r + 1, c);
        if (hit == PROBE_GO_ON && c + 1 < side) hit = probe(r, c + 1);
        if (hit == PROBE_GO_ON && c >= 1) hit = probe(r, c - 1);
        if (hit == PROBE_GOAL) begin
          res.reached = 1'b1;
          break;
        end
        if (hit == PROBE_FULL) begin
          res.overflow = 1'b1;
          break;
        end
      end
      res.cells_expanded = count[11:0];
      return res;
    endfunction

    function void note_input(gmd_in_t it);
      if (it.action == ACT_LOAD)
        cells[it.row*GRID_DIM + it.col] = it.cell_open ? CELL_OPEN : CELL_WALL;
      else
        expected_q.push_back(search_maze());
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      errors++;
    endtask

    task check_result(gmd_out_t got);
      gmd_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result reached=%0b overflow=%0b count=%0d",
                         got.reached, got.overflow, got.cells_expanded));
        return;
      end
      want = expected_q.pop_front();
      if (got.reached !== want.reached)
        report($sformatf("reached got %0b want %0b", got.reached, want.reached));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
      if (got.cells_expanded !== want.cells_expanded)
        report($sformatf("cells_expanded got %0d want %0d",
                         got.cells_expanded, want.cells_expanded));
    endtask
  endclass

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  gmd_in_t     in_item       = '0;
  logic        cfg_valid     = 1'b0;
  logic [4:0]  cfg_grid_side = SIDE_RESET;
  logic        busy;
  logic        cfg_ready;
  logic        out_valid;
  gmd_out_t    out_result;

  maze_scoreboard sb = new();

  int unsigned items_sent   = 0;
  int unsigned stall_cycles = 0;
  bit          gapless      = 1'b0;  // set for phases with back-to-back items
  logic [4:0]  side_now     = SIDE_RESET;
  // Cells the driver has loaded at least once; a search must never read any other.
  bit          cell_known [GRID_DIM*GRID_DIM];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  grid_maze_dfs_search_unit #(
    .MAX_SIDE   (GRID_DIM),
    .STACK_DEPTH(STACK_LIMIT)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_result   (out_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_grid_side(cfg_grid_side)
  );

  // Monitor: everything is sampled at the rising edge, before the unit's registers
  // update. The result is checked before a same-edge item is noted; a result always
  // belongs to an earlier search, so the order only keeps the log readable.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_result);
      if (cfg_valid && cfg_ready) sb.set_side(cfg_grid_side);
      if (start && !busy) sb.note_input(in_item);
    end
  end

  // Watchdog: count edges at which no item, result or register write moves.
  always @(posedge clk) begin
    if (out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Drop start for a random gap after an accepted item: mostly none or short,
  // now and then long enough to cover a whole small search.
  task automatic pause_sender();
    int unsigned pick, n;
    if (gapless) return;
    pick = $urandom_range(0, 19);
    if (pick < 12) return;
    n = (pick < 18) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold the item on the port until an edge sees start high and busy low.
  // start stays high into the next item when no gap follows.
  task automatic send_item(gmd_in_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
    if (it.action == ACT_LOAD) cell_known[it.row*GRID_DIM + it.col] = 1'b1;
    pause_sender();
  endtask

  task automatic load_cell(int unsigned r, int unsigned c, bit is_open);
    gmd_in_t it;
    it.action    = ACT_LOAD;
    it.row       = 4'(r);
    it.col       = 4'(c);
    it.cell_open = is_open;
    send_item(it);
  endtask

  // A search ignores row, col and cell_open, so fill them with noise.
  task automatic run_search();
    gmd_in_t it;
    it.action    = ACT_SOLVE;
    it.row       = 4'($urandom);
    it.col       = 4'($urandom);
    it.cell_open = 1'($urandom);
    send_item(it);
  endtask

  // Hold the sender until every predicted result has arrived and the unit is idle,
  // then let a few more cycles pass. Checks at the falling edge keep clear of the
  // monitor, which pops predictions at the rising edge.
  task automatic wait_drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(logic [4:0] v);
    wait_drain();
    cfg_valid     <= 1'b1;
    cfg_grid_side <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    side_now = v;
  endtask

  // Load any active cell not yet written, so a search only reads defined cells.
  task automatic fill_unknown();
    int unsigned side;
    side = maze_scoreboard::clamp_side(side_now);
    for (int r = 0; r < side; r++)
      for (int c = 0; c < side; c++)
        if (!cell_known[r*GRID_DIM + c]) load_cell(r, c, $urandom_range(0, 1));
  endtask

  // Reload the whole active grid with a random open-cell density.
  task automatic build_maze(int unsigned side);
    int unsigned density;
    density = $urandom_range(40, 90);
    for (int r = 0; r < side; r++)
      for (int c = 0; c < side; c++)
        load_cell(r, c, $urandom_range(0, 99) < density);
  endtask

  initial begin
    int unsigned phase, side, mazes, kind, pick;
    logic [4:0]  side_val;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: smallest grid. Start opens right, goal sits below that cell.
    write_side(5'd2);
    load_cell(0, 0, 1'b1);
    load_cell(0, 1, 1'b1);
    load_cell(1, 0, 1'b0);
    load_cell(1, 1, 1'b0);
    // loads outside the active grid are stored but never read
    load_cell(15, 15, 1'b1);
    load_cell(15, 0, 1'b0);
    load_cell(0, 15, 1'b1);
    run_search();
    // no reload: the visited cells are walls now, so the start is boxed in
    run_search();
    load_cell(1, 0, 1'b1);
    run_search();
    // side below the legal range acts as the smallest grid
    write_side(5'd0);
    run_search();
    load_cell(0, 1, 1'b1);
    run_search();
    write_side(5'd1);
    load_cell(1, 0, 1'b1);
    load_cell(0, 1, 1'b1);
    run_search();

    // Random phases: a side write, then a few mazes, each ending in a search.
    // The first two phases cover the largest grid and a side above the range.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0) side_val = 5'd16;
      else if (phase == 1) side_val = 5'd31;
      else begin
        pick = $urandom_range(0, 15);
        if (pick < 11) side_val = 5'($urandom_range(2, 6));
        else if (pick < 14) side_val = 5'($urandom_range(7, 16));
        else if (pick == 14) side_val = 5'($urandom_range(0, 1));
        else side_val = 5'($urandom_range(17, 31));
      end
      write_side(side_val);
      side    = maze_scoreboard::clamp_side(side_val);
      gapless = ($urandom_range(0, 3) == 0);
      mazes   = (side > 8) ? $urandom_range(1, 2) : $urandom_range(2, 6);
      repeat (mazes) begin
        kind = $urandom_range(0, 9);
        if (kind < 7)
          build_maze(side);
        else if (kind < 9)
          // touch up a few cells of what the last search left behind
          repeat ($urandom_range(1, 4))
            load_cell($urandom_range(0, side - 1), $urandom_range(0, side - 1),
                      $urandom_range(0, 1));
        // otherwise keep the grid as the previous search left it; stray loads follow in every case
        repeat ($urandom_range(0, 2))
          load_cell($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
        fill_unknown();
        run_search();
      end
      phase++;
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
